// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/tmre_pkg.sv -----
// ----------------------------------------------------------------------------
// tmre_pkg
// Types, constants and helpers shared by the touch message report engine.
// ----------------------------------------------------------------------------
package tmre_pkg;

    localparam int FINGER_SLOTS_DEF = 10;
    localparam int SLOT_W           = 4;
    localparam int COORD_W          = 12;
    localparam int SIZE_W           = 6;
    localparam int PRES_W           = 8;
    localparam int HALF_W           = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 12;
    localparam int QUEUE_DEPTH      = 2;

    // Status bit positions.
    localparam int ST_SUPPRESS_BIT = 1;
    localparam int ST_AMP_BIT      = 2;
    localparam int ST_MOVE_BIT     = 4;
    localparam int ST_RELEASE_BIT  = 5;
    localparam int ST_PRESS_BIT    = 6;
    localparam int ST_DETECT_BIT   = 7;

    localparam logic [COORD_W-1:0] KEY_COLUMN_X_RST  = 12'd845;
    localparam logic [COORD_W-1:0] HOME_KEY_Y_RST    = 12'd95;
    localparam logic [COORD_W-1:0] MENU_KEY_Y_RST    = 12'd238;
    localparam logic [COORD_W-1:0] BACK_KEY_Y_RST    = 12'd382;
    localparam logic [HALF_W-1:0]  KEY_HALF_SIZE_RST = 8'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLUMN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_KEY_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MENU_KEY_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_KEY_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HALF_SIZE = 3'd4;

    typedef enum logic [1:0] {
        EV_KEY_PRESS   = 2'd0,
        EV_RELEASE_ALL = 2'd1,
        EV_CONTACT     = 2'd2,
        EV_FRAME_END   = 2'd3
    } evt_kind_t;

    typedef enum logic [1:0] {
        KC_HOME = 2'd0,
        KC_MENU = 2'd1,
        KC_BACK = 2'd2
    } key_code_t;

    typedef enum logic [1:0] {
        HEAD_NONE,
        HEAD_KEY,
        HEAD_RELEASE
    } head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_WALK,
        BK_FRAME
    } back_state_t;

    // Work handed from the classifier to the sequencer.
    typedef struct packed {
        head_t               head;
        key_code_t           key_code;
        logic                write_all;
        logic                clear_pressure;
        logic                frame;
        logic [SLOT_W-1:0]   slot;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SIZE_W-1:0]   size;
        logic [PRES_W-1:0]   pressure;
    } cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  size;
        logic [PRES_W-1:0]  pressure;
        logic               retired;
    } finger_t;

    // Inclusive square zone test around (cx, cy) with half side h.
    function automatic logic in_zone(
        input logic [COORD_W-1:0] px,
        input logic [COORD_W-1:0] py,
        input logic [COORD_W-1:0] cx,
        input logic [COORD_W-1:0] cy,
        input logic [HALF_W-1:0]  h
    );
        logic signed [COORD_W+1:0] sx;
        logic signed [COORD_W+1:0] sy;
        logic signed [COORD_W+1:0] scx;
        logic signed [COORD_W+1:0] scy;
        logic signed [COORD_W+1:0] sh;
        sx  = $signed({2'b00, px});
        sy  = $signed({2'b00, py});
        scx = $signed({2'b00, cx});
        scy = $signed({2'b00, cy});
        sh  = $signed({6'b000000, h});
        return (sx >= scx - sh) && (sx <= scx + sh) && (sy >= scy - sh) && (sy <= scy + sh);
    endfunction

endpackage

// ----- rtl/core/tmre_msg_if.sv -----
// ----------------------------------------------------------------------------
// tmre_msg_if
// Touch status message channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmre_msg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  status_bits;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [7:0]  report_id;
    logic [7:0]  touch_area;
    logic [7:0]  touch_amplitude;

    modport source (
        output valid, status_bits, x_pos, y_pos, report_id, touch_area, touch_amplitude,
        input  ready
    );
    modport sink (
        input  valid, status_bits, x_pos, y_pos, report_id, touch_area, touch_amplitude,
        output ready
    );
endinterface

// ----- rtl/core/tmre_evt_if.sv -----
// ----------------------------------------------------------------------------
// tmre_evt_if
// Input event channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmre_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [1:0]  key_code;
    logic [11:0] contact_x;
    logic [11:0] contact_y;
    logic [7:0]  contact_pressure;
    logic [5:0]  contact_size;
    logic [3:0]  current_slot;
    logic        last;

    modport source (
        output valid, event_kind, key_code, contact_x, contact_y, contact_pressure,
               contact_size, current_slot, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, key_code, contact_x, contact_y, contact_pressure,
               contact_size, current_slot, last,
        output ready
    );
endinterface

// ----- rtl/core/tmre_front.sv -----
// ----------------------------------------------------------------------------
// tmre_front
// Accepts messages, holds the key zone registers and the previous slot, and
// classifies each message into a command for the sequencer.
// ----------------------------------------------------------------------------
module tmre_front #(
    parameter int FINGER_SLOTS = tmre_pkg::FINGER_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tmre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmre_pkg::CFG_DATA_W-1:0] cfg_data,
    tmre_msg_if.sink                       msg,
    input  logic                           q_full,
    output logic                           push,
    output tmre_pkg::cmd_t                 push_cmd
);
    import tmre_pkg::*;

    logic [COORD_W-1:0] key_column_x_reg;
    logic [COORD_W-1:0] home_key_y_reg;
    logic [COORD_W-1:0] menu_key_y_reg;
    logic [COORD_W-1:0] back_key_y_reg;
    logic [HALF_W-1:0]  key_half_size_reg;
    logic               prev_valid_reg;
    logic [SLOT_W-1:0]  prev_slot_reg;

    logic [7:0]         slot8;
    logic               in_range;
    logic               keep;
    logic               accept;
    logic               detect;
    logic               release_bit;
    logic               hit_home;
    logic               hit_menu;
    logic               hit_back;
    logic               key_hit;
    logic               any_update;
    logic               updn;
    logic [SIZE_W-1:0]  area_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_column_x_reg  <= KEY_COLUMN_X_RST;
            home_key_y_reg    <= HOME_KEY_Y_RST;
            menu_key_y_reg    <= MENU_KEY_Y_RST;
            back_key_y_reg    <= BACK_KEY_Y_RST;
            key_half_size_reg <= KEY_HALF_SIZE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_COLUMN_X:  key_column_x_reg  <= cfg_data;
                CFG_HOME_KEY_Y:    home_key_y_reg    <= cfg_data;
                CFG_MENU_KEY_Y:    menu_key_y_reg    <= cfg_data;
                CFG_BACK_KEY_Y:    back_key_y_reg    <= cfg_data;
                CFG_KEY_HALF_SIZE: key_half_size_reg <= cfg_data[HALF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        slot8       = msg.report_id - 8'd2;
        in_range    = slot8 < 8'(FINGER_SLOTS);
        keep        = !msg.status_bits[ST_SUPPRESS_BIT] && in_range;
        detect      = msg.status_bits[ST_DETECT_BIT];
        release_bit = msg.status_bits[ST_RELEASE_BIT];
        hit_home    = in_zone(msg.x_pos, msg.y_pos, key_column_x_reg, home_key_y_reg,
                              key_half_size_reg);
        hit_menu    = in_zone(msg.x_pos, msg.y_pos, key_column_x_reg, menu_key_y_reg,
                              key_half_size_reg);
        hit_back    = in_zone(msg.x_pos, msg.y_pos, key_column_x_reg, back_key_y_reg,
                              key_half_size_reg);
        key_hit     = hit_home || hit_menu || hit_back;
        any_update  = msg.status_bits[ST_PRESS_BIT] || msg.status_bits[ST_MOVE_BIT]
                      || msg.status_bits[ST_AMP_BIT];
        updn        = (detect && !key_hit && msg.status_bits[ST_PRESS_BIT])
                      || (!detect && release_bit);
        area_size   = msg.touch_area[7:2];
        if (area_size == '0)
        begin
            area_size = SIZE_W'(1);
        end

        push_cmd.head = HEAD_NONE;
        if (detect && key_hit)
        begin
            push_cmd.head = HEAD_KEY;
        end
        else if (!detect && release_bit)
        begin
            push_cmd.head = HEAD_RELEASE;
        end
        push_cmd.key_code       = hit_home ? KC_HOME : (hit_menu ? KC_MENU : KC_BACK);
        push_cmd.write_all      = detect && !key_hit && any_update;
        push_cmd.clear_pressure = !detect && release_bit;
        push_cmd.frame          = (prev_valid_reg && prev_slot_reg >= slot8[SLOT_W-1:0])
                                  || updn;
        push_cmd.slot           = slot8[SLOT_W-1:0];
        push_cmd.x              = msg.x_pos;
        push_cmd.y              = msg.y_pos;
        push_cmd.size           = area_size;
        push_cmd.pressure       = msg.touch_amplitude;

        msg.ready = !q_full;
        accept    = msg.valid && !q_full;
        push      = accept && keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_slot_reg  <= '0;
        end
        else if (push)
        begin
            prev_valid_reg <= 1'b1;
            prev_slot_reg  <= slot8[SLOT_W-1:0];
        end
    end

endmodule

// ----- rtl/core/tmre_queue.sv -----
// ----------------------------------------------------------------------------
// tmre_queue
// Short command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmre_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmre_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output tmre_pkg::cmd_t head_cmd,
    output logic           empty
);
    import tmre_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    always_comb
    begin
        full        = count_reg == CNT_W'(QUEUE_DEPTH);
        empty       = count_reg == '0;
        head_cmd    = entry_reg[rd_ptr_reg];
        wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_PROP(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full || pop)
    `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

// ----- rtl/core/tmre_back.sv -----
// ----------------------------------------------------------------------------
// tmre_back
// Sequencer: applies table writes, emits the head result, walks the finger
// slots for contact reports and closes each frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmre_back #(
    parameter int FINGER_SLOTS = tmre_pkg::FINGER_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  tmre_pkg::cmd_t q_cmd,
    output logic           pop,
    tmre_evt_if.source     evt
);
    import tmre_pkg::*;

    localparam int IDX_W = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

    finger_t            table_reg [FINGER_SLOTS];
    back_state_t        state_reg;
    back_state_t        state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    cmd_t               cmd_reg;

    logic               out_valid_reg;
    evt_kind_t          out_kind_reg;
    key_code_t          out_code_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [PRES_W-1:0]  out_pres_reg;
    logic [SIZE_W-1:0]  out_size_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_last_reg;

    logic               can_emit;
    logic               load;
    evt_kind_t          load_kind;
    key_code_t          load_code;
    logic               load_contact;
    logic               load_last;
    logic               retire;
    finger_t            entry;
    logic [IDX_W-1:0]   wr_idx;

    always_comb
    begin
        can_emit     = !out_valid_reg || evt.ready;
        entry        = table_reg[idx_reg];
        wr_idx       = q_cmd.slot[IDX_W-1:0];
        state_next   = state_reg;
        idx_next     = idx_reg;
        pop          = 1'b0;
        load         = 1'b0;
        load_kind    = EV_FRAME_END;
        load_code    = KC_HOME;
        load_contact = 1'b0;
        load_last    = 1'b0;
        retire       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                    if (q_cmd.head != HEAD_NONE)
                    begin
                        state_next = BK_HEAD;
                    end
                    else if (q_cmd.frame)
                    begin
                        state_next = BK_WALK;
                    end
                end
            end
            BK_HEAD:
            begin
                if (can_emit)
                begin
                    load       = 1'b1;
                    load_kind  = (cmd_reg.head == HEAD_KEY) ? EV_KEY_PRESS : EV_RELEASE_ALL;
                    load_code  = (cmd_reg.head == HEAD_KEY) ? cmd_reg.key_code : KC_HOME;
                    load_last  = !cmd_reg.frame;
                    state_next = cmd_reg.frame ? BK_WALK : BK_IDLE;
                end
            end
            BK_WALK:
            begin
                // Retired slots are skipped without waiting on the output.
                if (entry.retired || can_emit)
                begin
                    if (!entry.retired)
                    begin
                        load         = 1'b1;
                        load_kind    = EV_CONTACT;
                        load_contact = 1'b1;
                        retire       = entry.pressure == '0;
                    end
                    if (idx_reg == IDX_W'(FINGER_SLOTS - 1))
                    begin
                        state_next = BK_FRAME;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            BK_FRAME:
            begin
                if (can_emit)
                begin
                    load       = 1'b1;
                    load_kind  = EV_FRAME_END;
                    load_last  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FINGER_SLOTS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop && q_cmd.write_all)
            begin
                table_reg[wr_idx].x        <= q_cmd.x;
                table_reg[wr_idx].y        <= q_cmd.y;
                table_reg[wr_idx].size     <= q_cmd.size;
                table_reg[wr_idx].pressure <= q_cmd.pressure;
                table_reg[wr_idx].retired  <= 1'b0;
            end
            else if (pop && q_cmd.clear_pressure)
            begin
                table_reg[wr_idx].pressure <= '0;
                table_reg[wr_idx].retired  <= 1'b0;
            end
            if (retire)
            begin
                table_reg[idx_reg].retired <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (load)
        begin
            out_kind_reg <= load_kind;
            out_code_reg <= load_code;
            out_x_reg    <= load_contact ? entry.x : '0;
            out_y_reg    <= load_contact ? entry.y : '0;
            out_pres_reg <= load_contact ? entry.pressure : '0;
            out_size_reg <= load_contact ? entry.size : '0;
            out_slot_reg <= load_contact ? cmd_reg.slot : '0;
            out_last_reg <= load_last;
        end
    end

    assign evt.valid            = out_valid_reg;
    assign evt.event_kind       = out_kind_reg;
    assign evt.key_code         = out_code_reg;
    assign evt.contact_x        = out_x_reg;
    assign evt.contact_y        = out_y_reg;
    assign evt.contact_pressure = out_pres_reg;
    assign evt.contact_size     = out_size_reg;
    assign evt.current_slot     = out_slot_reg;
    assign evt.last             = out_last_reg;

    `ASSERT_IMPLY(a_walk_needs_frame, clk, rst_n, state_reg == BK_WALK, cmd_reg.frame)
    `ASSERT_IMPLY(a_frame_end_last, clk, rst_n,
                  out_valid_reg && out_kind_reg == EV_FRAME_END, out_last_reg)
    `ASSERT_IMPLY(a_pop_only_idle, clk, rst_n, pop, state_reg == BK_IDLE)

endmodule

// ----- rtl/core/touch_message_report_engine.sv -----
// ----------------------------------------------------------------------------
// touch_message_report_engine
// Turns touch status messages into key, release, contact and frame events.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Content
//  msg      in   valid/ready        one touch status message
//  evt      out  valid/ready        one input event, last marks end of message
//  cfg      in   cfg_write strobe   key zone registers by index
//
//  A message is classified in the cycle it is taken and queued (two entries).
//  The sequencer takes a command, emits a key or release event, walks the
//  slot table and emits the frame end, in that order.
//  The finger table is cleared at once by reset; no clearing pass is needed.
//  A stalled evt channel holds the walk; msg stalls only when the queue fills.
// ----------------------------------------------------------------------------
module touch_message_report_engine #(
    parameter int FINGER_SLOTS = tmre_pkg::FINGER_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tmre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmre_pkg::CFG_DATA_W-1:0] cfg_data,
    tmre_msg_if.sink                        msg,
    tmre_evt_if.source                      evt
);
    import tmre_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    tmre_front #(
        .FINGER_SLOTS(FINGER_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg       (msg),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tmre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    tmre_back #(
        .FINGER_SLOTS(FINGER_SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (head_cmd),
        .pop     (pop),
        .evt     (evt)
    );

endmodule
